// ===== hw/rtl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair encryption package
// Shared constants, types, codes and square geometry helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

   localparam int GRID_SIDE = 5;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int LETTERS   = 26;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int FILL_W    = $clog2(CELLS + 1);
   localparam int COORD_W   = $clog2(GRID_SIDE);
   localparam int LETTER_W  = $clog2(LETTERS);
   localparam int CHAR_W    = 8;
   localparam int ASCII_W   = 7;
   localparam int CMD_W     = 2;
   localparam int RULE_W    = 2;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CELL_W-1:0]   cell_type;
   typedef logic [FILL_W-1:0]   fill_type;
   typedef logic [COORD_W-1:0]  coord_type;

   localparam letter_type IDX_I      = letter_type'(8);
   localparam letter_type IDX_J      = letter_type'(9);
   localparam letter_type IDX_LAST   = letter_type'(LETTERS - 1);
   localparam letter_type PAD_RESET  = letter_type'(23);

   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [ASCII_W-1:0] ASCII_LOWER_A = 7'h61;

   typedef enum logic [CMD_W-1:0] {
      CMD_KEY    = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_MSG    = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   typedef enum logic [RULE_W-1:0] {
      RULE_ROW  = 2'd0,
      RULE_COL  = 2'd1,
      RULE_RECT = 2'd2
   } rule_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_LOOK,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic key_place;
      logic fill_start;
      logic fill_step;
      logic msg_take;
      logic end_take;
      logic load_out;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    letter_ok;
      logic    key_ready;
      logic    held_valid;
      logic    walk_last;
      logic    out_free;
   } sts_type;

   function automatic coord_type cell_row(cell_type c);
      coord_type r;
      r = '0;
      for (int i = 1; i < GRID_SIDE; i++) begin
         if (c >= cell_type'(i * GRID_SIDE)) r = coord_type'(i);
      end
      return r;
   endfunction

   function automatic coord_type cell_col(cell_type c);
      cell_type base;
      base = cell_type'(int'(cell_row(c)) * GRID_SIDE);
      return coord_type'(c - base);
   endfunction

   function automatic coord_type coord_next(coord_type k);
      return (k == coord_type'(GRID_SIDE - 1)) ? '0 : coord_type'(k + 1'b1);
   endfunction

   function automatic cell_type cell_at(coord_type r, coord_type k);
      return cell_type'(int'(r) * GRID_SIDE + int'(k));
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfe_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command word and its character.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_req_if;
   logic                       valid;
   logic                       ready;
   logic [pfe_pkg::CMD_W-1:0]  cmd;
   logic [pfe_pkg::CHAR_W-1:0] character;

   modport source (output valid, output cmd, output character, input ready);
   modport sink   (input valid, input cmd, input character, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfe_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one enciphered pair word.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pfe_pkg::ASCII_W-1:0] cipher_first;
   logic [pfe_pkg::ASCII_W-1:0] cipher_second;
   logic [pfe_pkg::RULE_W-1:0]  pair_rule;
   logic                        padded;
   logic                        closes_message;

   modport source (output valid, output cipher_first, output cipher_second,
                   output pair_rule, output padded, output closes_message,
                   input ready);
   modport sink   (input valid, input cipher_first, input cipher_second,
                   input pair_rule, input padded, input closes_message,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Playfair controller
// Sequences key building, the alphabet walk and the two lookup steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pfe_pkg::sts_type sts,
   output pfe_pkg::ctl_type      ctl
);

   pfe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfe_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (sts.cmd)
                  pfe_pkg::CMD_KEY: begin
                     ctl.key_place = !sts.key_ready && sts.letter_ok;
                  end
                  pfe_pkg::CMD_FINISH: begin
                     if (!sts.key_ready) begin
                        ctl.fill_start = 1'b1;
                        state_in       = pfe_pkg::ST_FILL;
                     end
                  end
                  pfe_pkg::CMD_MSG: begin
                     if (sts.key_ready && sts.letter_ok) begin
                        ctl.msg_take = 1'b1;
                        if (sts.held_valid) state_in = pfe_pkg::ST_LOOK;
                     end
                  end
                  pfe_pkg::CMD_END: begin
                     if (sts.key_ready && sts.held_valid) begin
                        ctl.end_take = 1'b1;
                        state_in     = pfe_pkg::ST_LOOK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         pfe_pkg::ST_FILL: begin
            ctl.fill_step = 1'b1;
            if (sts.walk_last) state_in = pfe_pkg::ST_IDLE;
         end
         pfe_pkg::ST_LOOK: state_in = pfe_pkg::ST_CALC;
         pfe_pkg::ST_CALC: state_in = pfe_pkg::ST_EMIT;
         pfe_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = pfe_pkg::ST_IDLE;
            end
         end
         default: state_in = pfe_pkg::ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_datapath.sv =====
// ----------------------------------------------------------------------------
// Playfair datapath
// Letter folding, key square stores, pair forming and the cipher rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire pfe_pkg::letter_type         csr_wr_data,
   input  wire logic [pfe_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [pfe_pkg::CHAR_W-1:0]  req_character,
   input  wire pfe_pkg::ctl_type            ctl,
   output pfe_pkg::sts_type                 sts,
   input  wire logic                        rsp_ready,
   output logic                             rsp_valid,
   output logic [pfe_pkg::ASCII_W-1:0]      rsp_first,
   output logic [pfe_pkg::ASCII_W-1:0]      rsp_second,
   output logic [pfe_pkg::RULE_W-1:0]       rsp_rule,
   output logic                             rsp_padded,
   output logic                             rsp_closes
);

   pfe_pkg::letter_type       pad_ff;
   logic [pfe_pkg::LETTERS-1:0] used_ff;
   pfe_pkg::fill_type         fill_ff;
   pfe_pkg::letter_type       walk_ff;
   logic                      key_ready_ff;
   logic                      held_valid_ff;
   pfe_pkg::letter_type       held_ff;
   pfe_pkg::letter_type       a_ff, b_ff;
   logic                      padded_ff, closes_ff;
   logic                      rsp_valid_ff;
   logic [pfe_pkg::ASCII_W-1:0] first_ff, second_ff;
   pfe_pkg::rule_type         rule_ff, rule_in;

   logic [pfe_pkg::CHAR_W-1:0] lower_off, upper_off;
   logic                      lower_hit, upper_hit;
   pfe_pkg::letter_type       raw_idx, fold_idx, pad_idx;

   logic                      place_en, place_go;
   pfe_pkg::letter_type       place_idx;

   pfe_pkg::cell_type         lc_a, lc_b, ks_addr_a, ks_addr_b;
   pfe_pkg::letter_type       ks_a, ks_b;
   pfe_pkg::coord_type        r1, r2, k1, k2;

   // fold letters, j to i
   assign lower_off = req_character - pfe_pkg::CHAR_LOWER_A;
   assign upper_off = req_character - pfe_pkg::CHAR_UPPER_A;
   assign lower_hit = (req_character >= pfe_pkg::CHAR_LOWER_A) &&
                      (req_character <= pfe_pkg::CHAR_LOWER_Z);
   assign upper_hit = (req_character >= pfe_pkg::CHAR_UPPER_A) &&
                      (req_character <= pfe_pkg::CHAR_UPPER_Z);
   assign raw_idx   = lower_hit ? lower_off[pfe_pkg::LETTER_W-1:0]
                                : upper_off[pfe_pkg::LETTER_W-1:0];
   assign fold_idx  = (raw_idx == pfe_pkg::IDX_J) ? pfe_pkg::IDX_I : raw_idx;

   always_comb begin
      pad_idx = pad_ff;
      if (pad_ff > pfe_pkg::IDX_LAST) pad_idx = pfe_pkg::IDX_LAST;
      else if (pad_ff == pfe_pkg::IDX_J) pad_idx = pfe_pkg::IDX_I;
   end

   // key placement
   always_comb begin
      place_idx = ctl.fill_step ? walk_ff : fold_idx;
      place_en  = ctl.key_place || (ctl.fill_step && walk_ff != pfe_pkg::IDX_J);
      place_go  = place_en && !used_ff[place_idx] &&
                  (fill_ff < pfe_pkg::fill_type'(pfe_pkg::CELLS));
   end

   pfe_ram #(.WIDTH(pfe_pkg::CELL_W), .DEPTH(pfe_pkg::LETTERS)) u_letter_cell (
      .clock     (clock),
      .wr_en     (place_go),
      .wr_addr   (place_idx),
      .wr_data   (fill_ff[pfe_pkg::CELL_W-1:0]),
      .rd_addr_a (a_ff),
      .rd_addr_b (b_ff),
      .rd_data_a (lc_a),
      .rd_data_b (lc_b)
   );

   pfe_ram #(.WIDTH(pfe_pkg::LETTER_W), .DEPTH(pfe_pkg::CELLS)) u_key_square (
      .clock     (clock),
      .wr_en     (place_go),
      .wr_addr   (fill_ff[pfe_pkg::CELL_W-1:0]),
      .wr_data   (place_idx),
      .rd_addr_a (ks_addr_a),
      .rd_addr_b (ks_addr_b),
      .rd_data_a (ks_a),
      .rd_data_b (ks_b)
   );

   // row, column and rectangle rules
   always_comb begin
      r1 = pfe_pkg::cell_row(lc_a);
      r2 = pfe_pkg::cell_row(lc_b);
      k1 = pfe_pkg::cell_col(lc_a);
      k2 = pfe_pkg::cell_col(lc_b);
      if (r1 == r2) begin
         ks_addr_a = pfe_pkg::cell_at(r1, pfe_pkg::coord_next(k1));
         ks_addr_b = pfe_pkg::cell_at(r2, pfe_pkg::coord_next(k2));
         rule_in   = pfe_pkg::RULE_ROW;
      end else if (k1 == k2) begin
         ks_addr_a = pfe_pkg::cell_at(pfe_pkg::coord_next(r1), k1);
         ks_addr_b = pfe_pkg::cell_at(pfe_pkg::coord_next(r2), k2);
         rule_in   = pfe_pkg::RULE_COL;
      end else begin
         ks_addr_a = pfe_pkg::cell_at(r1, k2);
         ks_addr_b = pfe_pkg::cell_at(r2, k1);
         rule_in   = pfe_pkg::RULE_RECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff        <= pfe_pkg::PAD_RESET;
         used_ff       <= '0;
         fill_ff       <= '0;
         walk_ff       <= '0;
         key_ready_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) pad_ff <= csr_wr_data;
         if (place_go) begin
            used_ff[place_idx] <= 1'b1;
            fill_ff            <= pfe_pkg::fill_type'(fill_ff + 1'b1);
         end
         if (ctl.fill_start) walk_ff <= '0;
         if (ctl.fill_step) begin
            walk_ff <= pfe_pkg::letter_type'(walk_ff + 1'b1);
            if (walk_ff == pfe_pkg::IDX_LAST) key_ready_ff <= 1'b1;
         end
         if (ctl.msg_take) begin
            if (!held_valid_ff) begin
               held_ff       <= fold_idx;
               held_valid_ff <= 1'b1;
            end else if (fold_idx != held_ff) begin
               held_ff       <= '0;
               held_valid_ff <= 1'b0;
            end
         end
         if (ctl.end_take) begin
            held_ff       <= '0;
            held_valid_ff <= 1'b0;
         end
         if (ctl.load_out)   rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // pair and result words
   always_ff @(posedge clock) begin
      if (ctl.msg_take && held_valid_ff) begin
         a_ff      <= held_ff;
         b_ff      <= (fold_idx == held_ff) ? pad_idx : fold_idx;
         padded_ff <= (fold_idx == held_ff);
         closes_ff <= 1'b0;
      end
      if (ctl.end_take) begin
         a_ff      <= held_ff;
         b_ff      <= pad_idx;
         padded_ff <= 1'b1;
         closes_ff <= 1'b1;
      end
      if (ctl.load_out) begin
         first_ff   <= pfe_pkg::ASCII_LOWER_A + pfe_pkg::ASCII_W'(ks_a);
         second_ff  <= pfe_pkg::ASCII_LOWER_A + pfe_pkg::ASCII_W'(ks_b);
         rule_ff    <= rule_in;
         rsp_padded <= padded_ff;
         rsp_closes <= closes_ff;
      end
   end

   always_comb begin
      sts.cmd        = pfe_pkg::cmd_type'(req_cmd);
      sts.letter_ok  = lower_hit || upper_hit;
      sts.key_ready  = key_ready_ff;
      sts.held_valid = held_valid_ff;
      sts.walk_last  = (walk_ff == pfe_pkg::IDX_LAST);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_first  = first_ff;
   assign rsp_second = second_ff;
   assign rsp_rule   = rule_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/playfair_digraph_encrypt.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph encryption
// Builds a 5x5 key square from key words and enciphers message letter pairs.
// ----------------------------------------------------------------------------
// A key word is placed as it is accepted. Finish key is accepted, then walks
// the alphabet, one letter a cycle, placing each unused letter but j.
// A message letter that completes a pair, or end of message with a held
// letter, is followed by two registered store reads in turn, letter to
// cell and then cell to letter, before the result register loads; the load
// waits only while the previous result has not been taken. Any other word
// leaves the controller idle. Message words before finish key are dropped;
// the key is fixed until reset. pad_ff is written by csr_wr_en/csr_wr_data.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_encrypt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [pfe_pkg::LETTER_W-1:0] csr_wr_data,
   pfe_req_if.sink                         req,
   pfe_rsp_if.source                       rsp
);

   pfe_pkg::ctl_type ctl;
   pfe_pkg::sts_type sts;
   logic             req_ready;
   logic             rsp_valid;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   pfe_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_cmd       (req.cmd),
      .req_character (req.character),
      .ctl           (ctl),
      .sts           (sts),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp_valid),
      .rsp_first     (rsp.cipher_first),
      .rsp_second    (rsp.cipher_second),
      .rsp_rule      (rsp.pair_rule),
      .rsp_padded    (rsp.padded),
      .rsp_closes    (rsp.closes_message)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire
